// File: sv/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg: shared types and codes of the contiguous segment allocator
// Command and status codes, and the control bundle that drives each
// segment table cell.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam logic [1:0] CMD_ALLOCATE = 2'd0;
   localparam logic [1:0] CMD_RELEASE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
   localparam logic [2:0] ST_OVER_RELEASE = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW     = 3'd4;

   typedef struct packed {
      logic load;     // write a new segment into this cell
      logic shift;    // take the neighbor's segment (compaction)
      logic compare;  // register the start match against the address
   } cell_ctrl_type;

endpackage

// File: sv/csa_cell.sv
// ----------------------------------------------------------------------------
// csa_cell: one entry of the segment table
// Holds a segment start and length, takes a new segment or its upper
// neighbor's segment, and flags a start match.
// ----------------------------------------------------------------------------
module csa_cell
   import csa_pkg::*;
#(
   parameter int INDEX_WIDTH = 16
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [INDEX_WIDTH-1:0] load_start,
   input  logic [INDEX_WIDTH-1:0] load_length,
   input  logic [INDEX_WIDTH-1:0] next_start,
   input  logic [INDEX_WIDTH-1:0] next_length,
   input  logic [INDEX_WIDTH-1:0] cmp_address,
   output logic [INDEX_WIDTH-1:0] start,
   output logic [INDEX_WIDTH-1:0] length,
   output logic                   match
);

   logic [INDEX_WIDTH-1:0] start_ff, start_in;
   logic [INDEX_WIDTH-1:0] length_ff, length_in;
   logic                   match_ff, match_in;

   always_comb begin
      start_in  = start_ff;
      length_in = length_ff;
      match_in  = match_ff;
      priority if (ctrl.load) begin
         start_in  = load_start;
         length_in = load_length;
      end else if (ctrl.shift) begin
         start_in  = next_start;
         length_in = next_length;
      end else begin
         start_in  = start_ff;
         length_in = length_ff;
      end
      if (ctrl.compare) begin
         match_in = (start_ff == cmp_address);
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      length_ff <= length_in;
      match_ff  <= match_in;
   end

   assign start  = start_ff;
   assign length = length_ff;
   assign match  = match_ff;

endmodule

// File: sv/contiguous_segment_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_segment_allocator: bump allocator with an ordered segment table
// Sequence: an allocate, clear or unused request goes through DONE; a release
// through MATCH, FIND and DONE, and one that succeeds in reuse mode through
// MATCH, FIND, REWIND and DONE (match, select, rewind). One request at a time,
// the next taken the cycle after the response is registered; a stalled
// response holds the next request off.
// Synchronous reset clears counters, table occupancy and reuse mode; no
// clearing pass, table contents are not reset.
// ----------------------------------------------------------------------------
module contiguous_segment_allocator
   import csa_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int INDEX_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_count,
   input  logic [15:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_start_index,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_in_use,
   output logic [15:0] rsp_next_index,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int OW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {IDLE, MATCH, FIND, REWIND, DONE} state_type;

   state_type              state_ff, state_in;
   logic                   reuse_ff, reuse_in;
   logic [INDEX_WIDTH-1:0] next_ff, next_in;
   logic [INDEX_WIDTH-1:0] used_ff, used_in;
   logic [OW-1:0]          occ_ff, occ_in;
   logic [INDEX_WIDTH-1:0] addr_ff, addr_in;
   logic [INDEX_WIDTH-1:0] res_start_ff, res_start_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_start_ff, rsp_start_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [15:0]            rsp_used_ff, rsp_used_in;
   logic [15:0]            rsp_next_ff, rsp_next_in;

   logic [INDEX_WIDTH-1:0] cnt;
   logic [INDEX_WIDTH:0]   sum_next, sum_used;
   logic                   alloc_load, compare;
   logic [TABLE_DEPTH-1:0] shift_vec, valid, hit, low, last_hot;
   logic [INDEX_WIDTH-1:0] sel_len, last_start, last_len, last_end;
   logic [INDEX_WIDTH-1:0] cell_start [TABLE_DEPTH];
   logic [INDEX_WIDTH-1:0] cell_len [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_match;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      cell_ctrl_type          ctrl;
      logic [INDEX_WIDTH-1:0] nb_start, nb_len;

      assign ctrl.load    = alloc_load && (occ_ff == OW'(k));
      assign ctrl.shift   = shift_vec[k];
      assign ctrl.compare = compare;
      assign valid[k]     = OW'(k) < occ_ff;

      if (k == TABLE_DEPTH - 1) begin : g_end
         assign nb_start    = '0;
         assign nb_len      = '0;
         assign last_hot[k] = valid[k];
      end else begin : g_mid
         assign nb_start    = cell_start[k+1];
         assign nb_len      = cell_len[k+1];
         assign last_hot[k] = valid[k] & ~valid[k+1];
      end

      csa_cell #(.INDEX_WIDTH(INDEX_WIDTH)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .load_start  (next_ff),
         .load_length (cnt),
         .next_start  (nb_start),
         .next_length (nb_len),
         .cmp_address (addr_ff),
         .start       (cell_start[k]),
         .length      (cell_len[k]),
         .match       (cell_match[k])
      );
   end

   assign cnt      = INDEX_WIDTH'(req_count);
   assign sum_next = {1'b0, next_ff} + {1'b0, cnt};
   assign sum_used = {1'b0, used_ff} + {1'b0, cnt};
   assign hit      = cell_match & valid;
   assign low      = hit & (~hit + 1'b1);

   always_comb begin
      sel_len    = '0;
      last_start = '0;
      last_len   = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         sel_len    = sel_len    | (cell_len[k]   & {INDEX_WIDTH{low[k]}});
         last_start = last_start | (cell_start[k] & {INDEX_WIDTH{last_hot[k]}});
         last_len   = last_len   | (cell_len[k]   & {INDEX_WIDTH{last_hot[k]}});
      end
   end

   assign last_end = last_start + last_len;

   always_comb begin
      state_in      = state_ff;
      reuse_in      = reuse_ff;
      next_in       = next_ff;
      used_in       = used_ff;
      occ_in        = occ_ff;
      addr_in       = addr_ff;
      res_start_in  = res_start_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_next_in   = rsp_next_ff;
      alloc_load    = 1'b0;
      compare       = 1'b0;
      shift_vec     = '0;

      if (csr_write_enable) begin
         reuse_in = csr_write_data;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               addr_in       = INDEX_WIDTH'(req_address);
               res_start_in  = '0;
               res_status_in = ST_OK;
               state_in      = DONE;
               unique case (req_cmd)
                  CMD_ALLOCATE: begin
                     priority if (occ_ff == OW'(TABLE_DEPTH)) begin
                        res_status_in = ST_TABLE_FULL;
                     end else if (sum_next[INDEX_WIDTH] || sum_used[INDEX_WIDTH]) begin
                        res_status_in = ST_OVERFLOW;
                     end else begin
                        res_start_in = next_ff;
                        next_in      = sum_next[INDEX_WIDTH-1:0];
                        used_in      = sum_used[INDEX_WIDTH-1:0];
                        occ_in       = occ_ff + 1'b1;
                        alloc_load   = 1'b1;
                     end
                  end
                  CMD_RELEASE: begin
                     state_in = MATCH;
                  end
                  CMD_CLEAR: begin
                     next_in = '0;
                     used_in = '0;
                     occ_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         MATCH: begin
            compare  = 1'b1;
            state_in = FIND;
         end
         FIND: begin
            state_in = DONE;
            priority if (hit == '0) begin
               res_status_in = ST_NOT_FOUND;
            end else if (reuse_ff && (sel_len > used_ff)) begin
               res_status_in = ST_OVER_RELEASE;
            end else begin
               shift_vec = ~(low - 1'b1);
               occ_in    = occ_ff - 1'b1;
               if (reuse_ff) begin
                  used_in  = used_ff - sel_len;
                  state_in = REWIND;
               end
            end
         end
         REWIND: begin
            next_in  = (occ_ff == '0) ? '0 : last_end;
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = 16'(res_start_ff);
               rsp_status_in = res_status_ff;
               rsp_used_in   = 16'(used_ff);
               rsp_next_in   = 16'(next_ff);
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         reuse_ff     <= 1'b0;
         next_ff      <= '0;
         used_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reuse_ff     <= reuse_in;
         next_ff      <= next_in;
         used_ff      <= used_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      res_start_ff  <= res_start_in;
      res_status_ff <= res_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_next_ff   <= rsp_next_in;
   end

   assign req_ready       = (state_ff == IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_index = rsp_start_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_in_use      = rsp_used_ff;
   assign rsp_next_index  = rsp_next_ff;

endmodule

// File: sv/csa_checker.sv
// ----------------------------------------------------------------------------
// csa_checker: port level checks of the contiguous segment allocator
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module csa_checker
   import csa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_start_index,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_in_use,
   input logic [15:0] rsp_next_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_index)
         && $stable(rsp_status) && $stable(rsp_in_use) && $stable(rsp_next_index))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_err_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_start_index == 16'd0))
      else $error("failed request returned a start index");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_NOT_FOUND)
         || (rsp_status == ST_OVER_RELEASE) || (rsp_status == ST_TABLE_FULL)
         || (rsp_status == ST_OVERFLOW))
      else $error("undefined status code");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind contiguous_segment_allocator csa_checker u_csa_checker (.*);

// File: tb/sv/tb_contiguous_segment_allocator.sv
// ----------------------------------------------------------------------------
// tb_contiguous_segment_allocator: self-checking bench for the segment allocator
// A directed table covers the corners first: empty and full-width segments,
// both overflow paths, unknown starts, a full table, the clear and unused
// commands, and rewind in reuse mode. Random phases with the reuse mode
// alternating follow. Each response is compared with its row's typed reply or
// an in-bench model of the segment table, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_contiguous_segment_allocator;
   import csa_pkg::*;

   localparam int TABLE_SLOTS = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_REQUESTS = 285;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] start_index;
      logic [2:0]  status;
      logic [15:0] in_use;
      logic [15:0] next_index;
   } alloc_reply_type;

   typedef struct packed {
      logic            csr;
      logic            reuse_val;
      logic [1:0]      cmd;
      logic [15:0]     count;
      logic [15:0]     address;
      logic [4:0]      reps;
      logic            typed;
      alloc_reply_type want;
   } stim_row_type;

   localparam alloc_reply_type PREDICTED = '0;
   localparam int NUM_ROWS = 15;

   // typed rows carry the response; the rest take the model's
   localparam stim_row_type plan [NUM_ROWS] = '{
      '{1'b1, 1'b0, CMD_ALLOCATE, 16'h0000, 16'h0000, 5'd0, 1'b0, PREDICTED},
      '{1'b0, 1'b0, CMD_ALLOCATE, 16'h0000, 16'h0000, 5'd1, 1'b1,
        '{16'h0000, ST_OK, 16'h0000, 16'h0000}},
      '{1'b0, 1'b0, CMD_ALLOCATE, 16'hFFFF, 16'hFFFF, 5'd1, 1'b1,
        '{16'h0000, ST_OK, 16'hFFFF, 16'hFFFF}},
      '{1'b0, 1'b0, CMD_ALLOCATE, 16'h0001, 16'h0000, 5'd1, 1'b1,
        '{16'h0000, ST_OVERFLOW, 16'hFFFF, 16'hFFFF}},
      '{1'b0, 1'b0, CMD_RELEASE, 16'hFFFF, 16'h1234, 5'd1, 1'b1,
        '{16'h0000, ST_NOT_FOUND, 16'hFFFF, 16'hFFFF}},
      '{1'b0, 1'b0, CMD_RELEASE, 16'h0000, 16'h0000, 5'd1, 1'b1,
        '{16'h0000, ST_OK, 16'hFFFF, 16'hFFFF}},
      '{1'b0, 1'b0, CMD_UNUSED, 16'hFFFF, 16'hFFFF, 5'd1, 1'b1,
        '{16'h0000, ST_OK, 16'hFFFF, 16'hFFFF}},
      '{1'b0, 1'b0, CMD_CLEAR, 16'h5A5A, 16'hA5A5, 5'd1, 1'b1,
        '{16'h0000, ST_OK, 16'h0000, 16'h0000}},
      '{1'b0, 1'b0, CMD_ALLOCATE, 16'h0100, 16'h0000, 5'd16, 1'b0, PREDICTED},
      '{1'b0, 1'b0, CMD_ALLOCATE, 16'h0001, 16'h0000, 5'd1, 1'b1,
        '{16'h0000, ST_TABLE_FULL, 16'h1000, 16'h1000}},
      '{1'b0, 1'b0, CMD_RELEASE, 16'h0000, 16'h0F00, 5'd1, 1'b0, PREDICTED},
      '{1'b1, 1'b1, CMD_ALLOCATE, 16'h0000, 16'h0000, 5'd0, 1'b0, PREDICTED},
      '{1'b0, 1'b0, CMD_RELEASE, 16'h0000, 16'h0E00, 5'd1, 1'b0, PREDICTED},
      // in-use total overflows while the end index still fits
      '{1'b0, 1'b0, CMD_ALLOCATE, 16'hF150, 16'h0000, 5'd1, 1'b1,
        '{16'h0000, ST_OVERFLOW, 16'h0F00, 16'h0E00}},
      '{1'b0, 1'b0, CMD_RELEASE, 16'h0000, 16'h0700, 5'd1, 1'b0, PREDICTED}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_ALLOCATE;
   logic [15:0] req_count = '0;
   logic [15:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_start_index;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_in_use;
   logic [15:0] rsp_next_index;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   // segment table model
   logic        reuse_mode = 1'b0;
   logic [15:0] free_ptr = '0;
   logic [15:0] in_use_total = '0;
   int          seg_count = 0;
   logic [15:0] tbl_start [TABLE_SLOTS];
   logic [15:0] tbl_len [TABLE_SLOTS];

   alloc_reply_type replies_due [$];

   int mismatches = 0;
   int responses_seen = 0;
   int cycles = 0;
   int burst_left = 0;
   int csr_writes = 0;
   int cmd_seen [4] = '{default: 0};
   int status_seen [8] = '{default: 0};

   always #5 clock = ~clock;

   contiguous_segment_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_count        (req_count),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_index  (rsp_start_index),
      .rsp_status       (rsp_status),
      .rsp_in_use       (rsp_in_use),
      .rsp_next_index   (rsp_next_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   function automatic alloc_reply_type step_allocator(input logic [1:0] cmd,
                                                      input logic [15:0] cnt,
                                                      input logic [15:0] addr);
      alloc_reply_type r;
      int pos;
      int k;
      r = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_ALLOCATE: begin
            if (seg_count >= TABLE_SLOTS) begin
               r.status = ST_TABLE_FULL;
            end else if (int'(free_ptr) + int'(cnt) > 32'hFFFF ||
                         int'(in_use_total) + int'(cnt) > 32'hFFFF) begin
               r.status = ST_OVERFLOW;
            end else begin
               tbl_start[seg_count] = free_ptr;
               tbl_len[seg_count] = cnt;
               seg_count++;
               r.start_index = free_ptr;
               free_ptr = free_ptr + cnt;
               in_use_total = in_use_total + cnt;
            end
         end
         CMD_RELEASE: begin
            pos = 0;
            while (pos < seg_count && tbl_start[pos] != addr) pos++;
            if (pos >= seg_count) begin
               r.status = ST_NOT_FOUND;
            end else if (reuse_mode && tbl_len[pos] > in_use_total) begin
               r.status = ST_OVER_RELEASE;
            end else begin
               if (reuse_mode) in_use_total = in_use_total - tbl_len[pos];
               for (k = pos; k + 1 < seg_count; k++) begin
                  tbl_start[k] = tbl_start[k + 1];
                  tbl_len[k] = tbl_len[k + 1];
               end
               seg_count--;
               if (reuse_mode) begin
                  if (seg_count == 0) free_ptr = '0;
                  else free_ptr = tbl_start[seg_count - 1] + tbl_len[seg_count - 1];
               end
            end
         end
         CMD_CLEAR: begin
            free_ptr = '0;
            in_use_total = '0;
            seg_count = 0;
         end
         default: ;
      endcase
      r.in_use = in_use_total;
      r.next_index = free_ptr;
      return r;
   endfunction

   task automatic send_request(input logic [1:0] cmd, input logic [15:0] cnt,
                               input logic [15:0] addr, input logic typed,
                               input alloc_reply_type want);
      alloc_reply_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_count <= cnt;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
      predicted = step_allocator(cmd, cnt, addr);
      replies_due.push_back(typed ? want : predicted);
      cmd_seen[cmd]++;
   endtask

   // block must be idle: drain responses, let the pipeline settle, then write
   task automatic write_reuse(input logic value);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reuse_mode = value;
      csr_writes++;
      burst_left = 0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      alloc_reply_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (replies_due.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request outstanding, expected none, got %0h %0h",
                     $time, rsp_status, rsp_start_index);
         end else begin
            due = replies_due.pop_front();
            check_field("start_index", due.start_index, rsp_start_index);
            check_field("status", due.status, rsp_status);
            check_field("in_use", due.in_use, rsp_in_use);
            check_field("next_index", due.next_index, rsp_next_index);
            status_seen[rsp_status]++;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin : response_sink
      int stretch;
      int mode;
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         stretch = $urandom_range(10, 60);
         mode = $urandom_range(0, 2);
         repeat (stretch) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         if (!long_hold_done && responses_seen >= 400) begin
            long_hold_done = 1'b1;
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time, replies_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int roll;
      logic [1:0] cmd;
      logic [15:0] cnt;
      logic [15:0] addr;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].csr) begin
            write_reuse(plan[i].reuse_val);
         end else begin
            repeat (plan[i].reps)
               send_request(plan[i].cmd, plan[i].count, plan[i].address,
                            plan[i].typed, plan[i].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_reuse(1'(phase % 2));
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            roll = $urandom_range(0, 99);
            cnt = 16'($urandom);
            addr = 16'($urandom);
            if (roll < 45) begin
               cmd = CMD_ALLOCATE;
               if (roll < 4) cnt = '0;
               else if (roll >= 8) cnt = 16'($urandom_range(1, 64));
            end else if (roll < 80) begin
               cmd = CMD_RELEASE;
               if (seg_count > 0) addr = tbl_start[$urandom_range(0, seg_count - 1)];
            end else if (roll < 88) begin
               cmd = CMD_RELEASE;
            end else if (roll < 93) begin
               cmd = CMD_CLEAR;
            end else if (roll < 96) begin
               cmd = CMD_UNUSED;
            end else begin
               cmd = CMD_ALLOCATE;
               cnt = 16'($urandom_range(16'h8000, 16'hFFFF));
            end
            send_request(cmd, cnt, addr, 1'b0, PREDICTED);
         end
      end

      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d requests: %0d allocate, %0d release, %0d clear, %0d unused; %0d reuse writes",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3], cmd_seen[CMD_ALLOCATE],
               cmd_seen[CMD_RELEASE], cmd_seen[CMD_CLEAR], cmd_seen[CMD_UNUSED], csr_writes);
      $display("Status counts: %0d ok, %0d not found, %0d table full, %0d overflow, %0d mismatches",
               status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_TABLE_FULL],
               status_seen[ST_OVERFLOW], mismatches);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: contiguous_segment_allocator.f
sv/csa_pkg.sv
sv/csa_cell.sv
sv/contiguous_segment_allocator.sv
sv/csa_checker.sv
tb/sv/tb_contiguous_segment_allocator.sv
